### rtl/rsti_pkg.sv
// Shared types and constants for the radix string-to-integer parser.
package rsti_pkg;

    localparam int MAX_RADIX = 36;
    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 6;
    localparam int MAG_W     = 63;
    localparam int VALUE_W   = 64;
    localparam int PROD_W    = MAG_W + RADIX_W;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [MAG_W-1:0]   MAG_MAX     = {MAG_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    // Register index of the radix register on the configuration port.
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_BASE = 2'd2
    } status_t;

    typedef struct packed {
        logic               is_sign;
        logic               is_minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

    typedef struct packed {
        status_t          status;
        logic             saturated;
        logic             negate;
        logic [MAG_W-1:0] magnitude;
    } result_t;

endpackage

### rtl/radix_string_to_integer.sv
// Top level of the radix string-to-integer parser: handshake, registers, APB port.
// Result path: a final character passes the input register stage and then the result
// register. Throughput: one character per cycle; the combinational multiply-accumulate
// loop on the magnitude register sets this rate. A final character held by a waiting
// result stalls the input behind it until that result is taken.
// Reset: synchronous, active low; clears the pipeline, the number state and sets radix to 10.
module radix_string_to_integer
    import rsti_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Character input channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CHAR_W-1:0]   s_char_code,
    input  logic                s_is_final,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [VALUE_W-1:0] m_value,
    output logic [1:0]          m_status,
    output logic                m_saturated,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    // Input register stage. A character sits here while the core works on it.
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_final_reg;

    // Result register stage.
    logic              m_valid_reg;
    status_t           out_status_reg;
    logic              out_sat_reg;
    logic              out_neg_reg;
    logic [MAG_W-1:0]  out_mag_reg;

    logic [RADIX_W-1:0] radix_reg;

    logic        out_free;
    logic        s1_fire;
    logic        cfg_write;
    char_class_t char_class;
    result_t     result;

    // A non-final character never needs the result register, so it always moves on.
    // A final character waits only while an earlier result is still not taken.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && (!s1_final_reg || out_free);
    assign s_ready  = !s1_valid_reg || s1_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_char_reg  <= s_char_code;
            s1_final_reg <= s_is_final;
        end
    end

    rsti_decode u_decode (
        .char_code  (s1_char_reg),
        .char_class (char_class)
    );

    rsti_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (s1_fire),
        .char_class (char_class),
        .is_final   (s1_final_reg),
        .radix      (radix_reg),
        .result     (result)
    );

    wire result_load = s1_fire && s1_final_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_load) begin
            out_status_reg <= result.status;
            out_sat_reg    <= result.saturated;
            out_neg_reg    <= result.negate;
            out_mag_reg    <= result.magnitude;
        end
    end

    // The sign is applied after the result register, which keeps the
    // negation off the multiply-accumulate path.
    assign m_valid     = m_valid_reg;
    assign m_status    = out_status_reg;
    assign m_saturated = out_sat_reg;
    assign m_value     = out_neg_reg ? (VALUE_W'(0) - VALUE_W'(out_mag_reg))
                                     : VALUE_W'(out_mag_reg);

    // Configuration: the radix register sits at byte address zero. Writes to
    // any other word are dropped and read back as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write && (paddr[APB_AW-1] == REG_RADIX)) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_RADIX) begin
            prdata = APB_DW'(radix_reg);
        end
    end

`ifndef ASSERT_OFF
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> ((m_value == '0) && !m_saturated))
        else $error("error result carries a nonzero value");
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_value == VALUE_W'(MAG_MAX)))
        else $error("saturated result is not the maximum value");
    a_final_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |=> m_valid_reg)
        else $error("final character produced no result");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !result_load)
        else $error("waiting result overwritten");
`endif

endmodule

### rtl/rsti_decode.sv
// Character classifier: sign detection and digit value of an ASCII code.
module rsti_decode
    import rsti_pkg::*;
(
    input  logic [CHAR_W-1:0] char_code,
    output char_class_t       char_class
);

    always_comb begin
        char_class          = '0;
        char_class.is_sign  = (char_code == CH_MINUS) || (char_code == CH_PLUS);
        char_class.is_minus = (char_code == CH_MINUS);
        if (char_code inside {[CH_ZERO:CH_NINE]}) begin
            char_class.is_digit = 1'b1;
            char_class.digit    = DIGIT_W'(char_code - CH_ZERO);
        end else if (char_code inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            char_class.is_digit = 1'b1;
            char_class.digit    = DIGIT_W'(char_code - CH_UPPER_A) + LETTER_BASE;
        end else if (char_code inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            char_class.is_digit = 1'b1;
            char_class.digit    = DIGIT_W'(char_code - CH_LOWER_A) + LETTER_BASE;
        end
    end

endmodule

### rtl/rsti_core.sv
// Number state and multiply-accumulate datapath, one character per cycle while fire is high.
module rsti_core
    import rsti_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  char_class_t        char_class,
    input  logic               is_final,
    input  logic [RADIX_W-1:0] radix,
    output result_t            result
);

    logic [MAG_W-1:0]  acc_reg, acc_next;
    logic              at_start_reg, at_start_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic              inv_reg, inv_next;
    logic              ovf_reg, ovf_next;
    logic              base_ok;
    logic              digit_ok;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic              sum_ovf;

    assign base_ok  = (radix >= RADIX_W'(2)) && (radix <= RADIX_W'(MAX_RADIX));
    assign digit_ok = char_class.is_digit && (char_class.digit < radix);
    assign prod     = PROD_W'(acc_reg) * PROD_W'(radix);
    assign sum      = prod + PROD_W'(char_class.digit);
    assign sum_ovf  = |sum[PROD_W-1:MAG_W];

    always_comb begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        seen_next     = seen_reg;
        inv_next      = inv_reg;
        ovf_next      = ovf_reg;
        at_start_next = 1'b0;

        if (at_start_reg && char_class.is_sign) begin
            neg_next = char_class.is_minus;
        end else if (!digit_ok) begin
            inv_next = 1'b1;
        end else begin
            seen_next = 1'b1;
            if (base_ok && !ovf_reg) begin
                if (sum_ovf) begin
                    ovf_next = 1'b1;
                    acc_next = MAG_MAX;
                end else begin
                    acc_next = sum[MAG_W-1:0];
                end
            end
        end

        result = '0;
        if (!base_ok) begin
            result.status = ST_BAD_BASE;
        end else if (inv_next || !seen_next) begin
            result.status = ST_BAD_CHAR;
        end else begin
            result.status    = ST_OK;
            result.saturated = ovf_next;
            result.negate    = neg_next && !ovf_next;
            result.magnitude = acc_next;
        end

        // The final character ends the number; the next one starts afresh.
        if (is_final) begin
            acc_next      = '0;
            at_start_next = 1'b1;
            neg_next      = 1'b0;
            seen_next     = 1'b0;
            inv_next      = 1'b0;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            at_start_reg <= 1'b1;
            neg_reg      <= 1'b0;
            seen_reg     <= 1'b0;
            inv_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
        end else if (fire) begin
            acc_reg      <= acc_next;
            at_start_reg <= at_start_next;
            neg_reg      <= neg_next;
            seen_reg     <= seen_next;
            inv_reg      <= inv_next;
            ovf_reg      <= ovf_next;
        end
    end

`ifndef ASSERT_OFF
    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_final) |=> (at_start_reg && (acc_reg == '0) && !ovf_reg))
        else $error("number state not cleared after final character");
    a_ovf_clamps: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (acc_reg == MAG_MAX))
        else $error("overflow without clamped magnitude");
    a_start_only_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_final) |=> !at_start_reg)
        else $error("start state held after a non-final character");
`endif

endmodule
